>>> hw/rtl/npta_pkg.sv
`timescale 1ns / 1ps

package npta_pkg;

	localparam int STACK_DEPTH_DEF = 8;
	localparam int PHASE_COUNT_DEF = 4;
	localparam int CLASS_COUNT_DEF = 20;

	localparam int TIME_W   = 64;
	localparam int CLASS_W  = 5;
	localparam int PHASE_W  = 3;
	localparam int OPCODE_W = 2;
	localparam int OPHASE_W = 2;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 72;

	localparam logic [OPCODE_W-1:0] OP_BEGIN = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_ENTER = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_LEAVE = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_END   = 2'd3;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [PHASE_W-1:0]  phase_id;
		logic [CLASS_W-1:0]  op_class;
		logic [TIME_W-1:0]   now_ns;
	} npta_event_t;

endpackage

>>> hw/rtl/npta_ram.sv
`timescale 1ns / 1ps

module npta_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/nested_phase_time_attribution.sv
`timescale 1ns / 1ps

// Nested phase time attribution.
// Input channel s_*: one event item per handshake. s_tuser carries the opcode
// (begin, enter, leave, end); s_tdata carries phase_id, op_class and now_ns.
// Output channel m_*: one (class, phase, ns) item per phase with a nonzero
// total after an end event, in increasing phase order; m_tlast marks the
// final item of that end event.
// cfg_we/cfg_wdata write the enable switch; the user is to write it only
// while idle, as the block does not enforce this. Begin and ignored events
// finish at acceptance. Enter, leave and end go through these steps in turn:
// accept and read the phase stack RAM, read the totals RAM, then write back
// the charged total. An end event with a valid class then sweeps the totals
// RAM phase by phase, loading one output item for each nonzero total.
// Reset clears the tracker to inactive, sets the enable switch and empties
// the output register; there is no clearing pass. A stalled receiver holds
// the output register and, during an end sweep, the sweep; new events are
// accepted once the sweep has passed the last phase.
module nested_phase_time_attribution #(
	parameter int STACK_DEPTH = npta_pkg::STACK_DEPTH_DEF,
	parameter int PHASE_COUNT = npta_pkg::PHASE_COUNT_DEF,
	parameter int CLASS_COUNT = npta_pkg::CLASS_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [2:0] phase_id, [7:3] op_class, [71:8] now_ns
	input  logic [npta_pkg::IN_DATA_W-1:0]     s_tdata,
	// [1:0] opcode
	input  logic [npta_pkg::OPCODE_W-1:0]      s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [4:0] out_class, [6:5] out_phase, [70:7] phase_ns, [71] zero
	output logic [npta_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                               m_tlast,
	input  logic                               cfg_we,
	input  logic                               cfg_wdata
);

	import npta_pkg::*;

	localparam int TOP_W = $clog2(STACK_DEPTH);
	localparam int PH_W  = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;

	// sequencer codes
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_STK   = 3'd1;
	localparam logic [2:0] S_TOT   = 3'd2;
	localparam logic [2:0] S_SWEEP = 3'd3;
	localparam logic [2:0] S_LOAD  = 3'd4;

	logic [2:0]             state_q;
	logic                   enabled_q;
	logic                   tracking_q;
	logic [TOP_W-1:0]       top_q;
	logic [TIME_W-1:0]      mark_q;
	logic [PHASE_COUNT-1:0] nz_q;      // phase total is nonzero
	logic [PH_W-1:0]        sweep_q;
	npta_event_t            ev_q;

	logic [PH_W-1:0]        ph_s1;
	logic [TIME_W-1:0]      delta_s1;

	logic                   out_valid_q;
	logic [CLASS_W-1:0]     out_class_q;
	logic [OPHASE_W-1:0]    out_phase_q;
	logic [TIME_W-1:0]      out_ns_q;
	logic                   out_last_q;

	npta_event_t            ev_in;
	logic                   accept;
	logic                   go_charge;
	logic                   phase_ok;
	logic                   class_ok;
	logic                   out_free;
	logic                   sweep_last;
	logic [PHASE_COUNT-1:0] nz_hi;

	logic                   stk_we;
	logic [TOP_W-1:0]       stk_waddr;
	logic [PH_W-1:0]        stk_wdata;
	logic                   stk_re;
	logic [PH_W-1:0]        stk_rdata;

	logic                   tot_we;
	logic [TIME_W-1:0]      tot_wdata;
	logic                   tot_re;
	logic [PH_W-1:0]        tot_raddr;
	logic [TIME_W-1:0]      tot_rdata;

	assign ev_in.opcode   = s_tuser;
	assign ev_in.phase_id = s_tdata[2:0];
	assign ev_in.op_class = s_tdata[7:3];
	assign ev_in.now_ns   = s_tdata[71:8];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign phase_ok = 32'(ev_in.phase_id) < PHASE_COUNT;
	assign class_ok = 32'(ev_q.op_class) < CLASS_COUNT;
	assign out_free = !out_valid_q || m_tready;

	// Decide at acceptance whether the event charges the top phase.
	always_comb begin
		unique case (ev_in.opcode)
			OP_ENTER: go_charge = tracking_q && phase_ok &&
				(top_q != TOP_W'(STACK_DEPTH - 1));
			OP_LEAVE: go_charge = tracking_q && (top_q != '0);
			OP_END:   go_charge = tracking_q;
			default:  go_charge = 1'b0;
		endcase
	end

	// Phase stack: begin writes the base entry, enter writes the pushed one.
	// Reads and writes of one event fall in different cycles, so no
	// same-entry overlap arises.
	assign stk_re    = accept && go_charge;
	assign stk_we    = (accept && (ev_in.opcode == OP_BEGIN) && enabled_q) ||
		((state_q == S_TOT) && (ev_q.opcode == OP_ENTER));
	assign stk_waddr = (state_q == S_TOT) ? (top_q + TOP_W'(1)) : '0;
	assign stk_wdata = (state_q == S_TOT) ? PH_W'(ev_q.phase_id) : '0;

	npta_ram #(
		.WIDTH(PH_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.re   (stk_re),
		.raddr(top_q),
		.rdata(stk_rdata)
	);

	// Totals: read the top phase for a charge, or the sweep index at an end.
	assign tot_re    = (state_q == S_STK) || ((state_q == S_SWEEP) && nz_q[sweep_q]);
	assign tot_raddr = (state_q == S_STK) ? stk_rdata : sweep_q;
	assign tot_we    = (state_q == S_TOT);
	// A total not written since begin reads as zero through its flag.
	assign tot_wdata = (nz_q[ph_s1] ? tot_rdata : '0) + delta_s1;

	npta_ram #(
		.WIDTH(TIME_W),
		.DEPTH(PHASE_COUNT)
	) u_totals (
		.clk  (clk),
		.we   (tot_we),
		.waddr(ph_s1),
		.wdata(tot_wdata),
		.re   (tot_re),
		.raddr(tot_raddr),
		.rdata(tot_rdata)
	);

	assign sweep_last = (sweep_q == PH_W'(PHASE_COUNT - 1));
	assign nz_hi      = nz_q >> sweep_q;

	// Payload registers of the event and the charge stage.
	always_ff @(posedge clk) begin
		if (accept) begin
			ev_q <= ev_in;
		end
		if (state_q == S_STK) begin
			ph_s1    <= stk_rdata;
			delta_s1 <= ev_q.now_ns - mark_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			enabled_q  <= 1'b1;
			tracking_q <= 1'b0;
			top_q      <= '0;
			nz_q       <= '0;
			sweep_q    <= '0;
			mark_q     <= '0;
		end else begin
			if (cfg_we) begin
				enabled_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (ev_in.opcode == OP_BEGIN) begin
							tracking_q <= enabled_q;
							if (enabled_q) begin
								top_q  <= '0;
								mark_q <= ev_in.now_ns;
								nz_q   <= '0;
							end
						end else if (go_charge) begin
							state_q <= S_STK;
						end
					end
				end
				S_STK: begin
					// advance the mark; the delta is captured alongside
					mark_q  <= ev_q.now_ns;
					state_q <= S_TOT;
				end
				S_TOT: begin
					nz_q[ph_s1] <= (tot_wdata != '0);
					state_q     <= S_IDLE;
					unique case (ev_q.opcode)
						OP_ENTER: top_q <= top_q + TOP_W'(1);
						OP_LEAVE: top_q <= top_q - TOP_W'(1);
						OP_END: begin
							tracking_q <= 1'b0;
							if (class_ok) begin
								sweep_q <= '0;
								state_q <= S_SWEEP;
							end
						end
						default: ;
					endcase
				end
				S_SWEEP: begin
					if (nz_q[sweep_q]) begin
						state_q <= S_LOAD;
					end else if (sweep_last) begin
						state_q <= S_IDLE;
					end else begin
						sweep_q <= sweep_q + PH_W'(1);
					end
				end
				S_LOAD: begin
					// hold the read data until the output register frees
					if (out_free) begin
						if (sweep_last) begin
							state_q <= S_IDLE;
						end else begin
							sweep_q <= sweep_q + PH_W'(1);
							state_q <= S_SWEEP;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register: load one item per nonzero phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_LOAD) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_LOAD) && out_free) begin
			out_class_q <= ev_q.op_class;
			out_phase_q <= OPHASE_W'(sweep_q);
			out_ns_q    <= tot_rdata;
			out_last_q  <= ((nz_hi >> 1) == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_ns_q, out_phase_q, out_class_q};
	assign m_tlast  = out_last_q;

endmodule

>>> hw/rtl/npta_checker.sv
`timescale 1ns / 1ps

module npta_sva #(
	parameter int CLASS_COUNT = npta_pkg::CLASS_COUNT_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [npta_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                            m_tlast
);

	import npta_pkg::*;

	// hold a stalled item
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output item dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[70:7] != '0))
		else $error("reported phase total is zero");

	a_class: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(m_tdata[4:0]) < CLASS_COUNT))
		else $error("reported class out of range");

endmodule

bind nested_phase_time_attribution npta_sva #(
	.CLASS_COUNT(CLASS_COUNT)
) u_npta_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
